@@ hdl/bcu_pkg.sv @@
// Shared widths and sequencer state codes for the binomial coefficient unit.
package bcu_pkg;

  localparam int unsigned N_W    = 6;   // n_total width
  localparam int unsigned K_W    = 7;   // k_chosen width, two's complement
  localparam int unsigned DIFF_W = 8;   // n - k, signed
  localparam int unsigned COEF_W = 57;  // result width
  localparam int unsigned FACT_W = 6;   // multiplier factor M+i, at most 60
  localparam int unsigned I_W    = 5;   // loop index / divisor, at most 30
  localparam int unsigned PROD_W = 62;  // every product stays below 2^62
  localparam int unsigned CNT_W  = 6;   // counts divide steps 0..PROD_W-1

  localparam int unsigned MUL_W  = COEF_W + FACT_W;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

  localparam int unsigned ST_W = 2;
  localparam logic [ST_W-1:0] S_IDLE = 2'd0;
  localparam logic [ST_W-1:0] S_MUL  = 2'd1;
  localparam logic [ST_W-1:0] S_DIV  = 2'd2;

endpackage

@@ hdl/binomial_coefficient_unit.sv @@
// Binomial coefficient unit: C(n,k) by the multiplicative formula on a shared
// multiply / restoring-divide datapath.
//
// Usage: drive n_total_i and k_chosen_i and raise start_i; the item is taken
// at a rising edge with start_i high and busy_o low. One result comes back on
// coefficient_o, marked by valid_o for exactly one cycle; the receiver cannot
// hold it off and must take it in that cycle.
// Out-of-range k (negative or above n) and n above MAX_N give 0; k equal to 0
// or n gives 1. These and the case min(k, n-k) = 1 answer on the next cycle and
// leave busy_o low, so such items can be started back to back.
// Otherwise, with m = min(k, n-k), the block runs m-1 rounds. Each round is
// a multiply by (M+i) in S_MUL followed by a one-bit-per-cycle restoring
// divide by i in S_DIV, and the result strobes after the divide of the last
// round. busy_o stays high for the whole computation.
// Reset clears the sequencer and the result strobe; no state survives an item.
module binomial_coefficient_unit #(
  parameter int unsigned MAX_N = 60
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic        [bcu_pkg::N_W-1:0]     n_total_i,
  input  logic signed [bcu_pkg::K_W-1:0]     k_chosen_i,
  output logic                               valid_o,
  output logic        [bcu_pkg::COEF_W-1:0]  coefficient_o
);

  logic [bcu_pkg::ST_W-1:0]   state_q, state_d;
  logic [bcu_pkg::COEF_W-1:0] acc_q, acc_d;
  logic [bcu_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [bcu_pkg::I_W-1:0]    rem_q, rem_d;
  logic [bcu_pkg::I_W-1:0]    i_q, i_d;
  logic [bcu_pkg::I_W-1:0]    small_q, small_d;
  logic [bcu_pkg::FACT_W-1:0] large_q, large_d;
  logic [bcu_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       valid_q, valid_d;
  logic [bcu_pkg::COEF_W-1:0] coef_q, coef_d;

  logic                              accept;
  logic signed [bcu_pkg::DIFF_W-1:0] k_ext, rest, small_s, large_s;
  logic [bcu_pkg::FACT_W-1:0]        factor;
  logic [bcu_pkg::MUL_W-1:0]         mul_full;
  logic [bcu_pkg::I_W:0]             rem_sh;
  logic                              quo_bit;

  assign accept = start_i && (state_q == bcu_pkg::S_IDLE);

  // Split n into the smaller and larger parts.
  assign k_ext   = bcu_pkg::DIFF_W'(k_chosen_i);
  assign rest    = $signed({2'b00, n_total_i}) - k_ext;
  assign small_s = (k_ext < rest) ? k_ext : rest;
  assign large_s = (k_ext < rest) ? rest : k_ext;

  assign factor   = large_q + bcu_pkg::FACT_W'(i_q);
  assign mul_full = bcu_pkg::MUL_W'(acc_q) * bcu_pkg::MUL_W'(factor);

  // One restoring divide step: quotient bits shift into the low end of prod.
  assign rem_sh  = {rem_q, prod_q[bcu_pkg::PROD_W-1]};
  assign quo_bit = rem_sh >= {1'b0, i_q};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    i_d     = i_q;
    small_d = small_q;
    large_d = large_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    coef_d  = coef_q;
    case (state_q)
      bcu_pkg::S_IDLE: begin
        if (accept) begin
          large_d = large_s[bcu_pkg::FACT_W-1:0];
          small_d = small_s[bcu_pkg::I_W-1:0];
          acc_d   = bcu_pkg::COEF_W'(large_s[bcu_pkg::FACT_W-1:0]) + 1'b1;
          i_d     = bcu_pkg::I_W'(2);
          if ((32'(n_total_i) > MAX_N) || (small_s < 0)) begin
            valid_d = 1'b1;
            coef_d  = '0;
          end else if (small_s == 0) begin
            valid_d = 1'b1;
            coef_d  = bcu_pkg::COEF_W'(1);
          end else if (small_s == 1) begin
            valid_d = 1'b1;
            coef_d  = bcu_pkg::COEF_W'(large_s[bcu_pkg::FACT_W-1:0]) + 1'b1;
          end else begin
            state_d = bcu_pkg::S_MUL;
          end
        end
      end
      bcu_pkg::S_MUL: begin
        prod_d  = mul_full[bcu_pkg::PROD_W-1:0];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = bcu_pkg::S_DIV;
      end
      bcu_pkg::S_DIV: begin
        rem_d  = quo_bit ? bcu_pkg::I_W'(rem_sh - {1'b0, i_q})
                         : rem_sh[bcu_pkg::I_W-1:0];
        prod_d = {prod_q[bcu_pkg::PROD_W-2:0], quo_bit};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == bcu_pkg::LAST_STEP) begin
          acc_d = prod_d[bcu_pkg::COEF_W-1:0];
          if (i_q == small_q) begin
            valid_d = 1'b1;
            coef_d  = prod_d[bcu_pkg::COEF_W-1:0];
            state_d = bcu_pkg::S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = bcu_pkg::S_MUL;
          end
        end
      end
      default: begin
        state_d = bcu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcu_pkg::S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    i_q     <= i_d;
    small_q <= small_d;
    large_q <= large_d;
    cnt_q   <= cnt_d;
    coef_q  <= coef_d;
  end

  assign busy_o        = (state_q != bcu_pkg::S_IDLE);
  assign valid_o       = valid_q;
  assign coefficient_o = coef_q;

  // Every accepted item either answers next cycle or keeps the unit busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> valid_o || busy_o)
    else $error("accepted item neither answered nor started");

  // The divide remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcu_pkg::S_DIV |-> rem_q < i_q)
    else $error("divide remainder not below divisor");

  // Loop index stays within 2..m while working.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (i_q >= bcu_pkg::I_W'(2)) && (i_q <= small_q))
    else $error("loop index out of range");

  // A strobe that follows a busy cycle can only come from the last divide step.
  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(busy_o) |-> $past(state_q) == bcu_pkg::S_DIV)
    else $error("result strobe outside the final divide step");

endmodule

@@ bench/tb_binomial_coefficient_unit.sv @@
// Self-checking bench for the binomial coefficient unit: directed table, random pairs.
`timescale 1ns / 100ps

module tb_binomial_coefficient_unit;

  localparam int unsigned MAX_N = 60;
  localparam int DIR_ROWS = 23;
  localparam int RAND_ITEMS = 300;

  typedef logic [bcu_pkg::N_W-1:0] n_t;
  typedef logic signed [bcu_pkg::K_W-1:0] k_t;
  typedef logic [bcu_pkg::COEF_W-1:0] coef_t;

  typedef struct {
    n_t n;
    k_t k;
    bit known;      // coef column holds the answer, otherwise predict it
    coef_t coef;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  n_t n_total_i;
  k_t k_chosen_i;
  logic valid_o;
  coef_t coefficient_o;

  coef_t pending_coefs[$];
  int mismatches = 0;
  int idle_pct = 9;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{6'd0, 7'sd0, 1'b1, 57'd1},
    '{6'd0, 7'sd1, 1'b1, 57'd0},
    '{6'd0, -7'sd1, 1'b1, 57'd0},
    '{6'd60, 7'sd0, 1'b1, 57'd1},
    '{6'd60, 7'sd60, 1'b1, 57'd1},
    '{6'd60, 7'sd61, 1'b1, 57'd0},
    '{6'd60, 7'sd63, 1'b1, 57'd0},
    '{6'd60, -7'sd64, 1'b1, 57'd0},
    '{6'd60, 7'sd30, 1'b1, 57'd118264581564861424},
    '{6'd60, 7'sd1, 1'b1, 57'd60},
    '{6'd60, 7'sd59, 1'b1, 57'd60},
    '{6'd61, 7'sd0, 1'b1, 57'd0},
    '{6'd63, 7'sd5, 1'b1, 57'd0},
    '{6'd62, -7'sd64, 1'b1, 57'd0},
    '{6'd63, 7'sd63, 1'b1, 57'd0},
    '{6'd1, 7'sd1, 1'b1, 57'd1},
    '{6'd2, 7'sd1, 1'b1, 57'd2},
    '{6'd59, 7'sd29, 1'b0, 57'd0},
    '{6'd42, 7'sd17, 1'b0, 57'd0},
    '{6'd7, 7'sd3, 1'b0, 57'd0},
    '{6'd33, 7'sd31, 1'b0, 57'd0},
    '{6'd12, 7'sd6, 1'b0, 57'd0},
    '{6'd45, 7'sd2, 1'b0, 57'd0}
  };

  binomial_coefficient_unit #(
    .MAX_N(MAX_N)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .n_total_i    (n_total_i),
    .k_chosen_i   (k_chosen_i),
    .valid_o      (valid_o),
    .coefficient_o(coefficient_o)
  );

  always #5 clk_i = ~clk_i;

  // C(n,k) by the multiplicative formula; every partial product fits in 64 bits
  function automatic coef_t choose_count(n_t n, k_t k);
    int nn;
    int kk;
    int rest;
    int m;
    int big;
    longint unsigned acc;
    nn = n;
    kk = k;
    if (nn > MAX_N) return '0;
    rest = nn - kk;
    m = (kk < rest) ? kk : rest;
    big = (kk < rest) ? rest : kk;
    if (m < 0) return '0;
    if (m == 0) return coef_t'(1);
    acc = longint'(big + 1);
    for (int i = 2; i <= m; i++) begin
      acc = (acc * longint'(big + i)) / longint'(i);
    end
    return acc[bcu_pkg::COEF_W-1:0];
  endfunction

  task automatic flag_mismatch(string what, coef_t want, coef_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected %0d, got %0d", what, want, got);
    end
  endtask

  // Called just after a rising edge; returns just after the edge of the transfer.
  task automatic issue_pair(n_t n, k_t k, coef_t want);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    n_total_i <= n;
    k_chosen_i <= k;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_coefs.push_back(want);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_coefs.size() != 0);
  endtask

  // Pairs biased toward short computations, with some long ones and some noise.
  task automatic issue_random();
    int sel;
    int n;
    int k;
    sel = $urandom_range(99);
    n = $urandom_range(MAX_N);
    if (sel < 50) begin
      k = ($urandom_range(1) != 0) ? $urandom_range(3) : n - $urandom_range(3);
    end else if (sel < 75) begin
      k = $urandom_range(n);
    end else if (sel < 85) begin
      k = ($urandom_range(1) != 0) ? -1 - $urandom_range(2) : n + 1 + $urandom_range(2);
    end else if (sel < 95) begin
      n = $urandom_range(63);
      k = $urandom_range(127) - 64;
    end else begin
      n = $urandom_range(63, MAX_N + 1);
      k = $urandom_range(127) - 64;
    end
    issue_pair(n_t'(n), k_t'(k), choose_count(n_t'(n), k_t'(k)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      if (pending_coefs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: unexpected result %0d", coefficient_o);
      end else if (coefficient_o !== pending_coefs[0]) begin
        flag_mismatch("coefficient", pending_coefs.pop_front(), coefficient_o);
      end else begin
        void'(pending_coefs.pop_front());
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    n_total_i <= '0;
    k_chosen_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      issue_pair(dir_rows[r].n, dir_rows[r].k,
                 dir_rows[r].known ? dir_rows[r].coef
                                   : choose_count(dir_rows[r].n, dir_rows[r].k));
    end
    wait_drained();

    for (int t = 0; t < RAND_ITEMS; t++) begin
      if (t == 100) idle_pct = 0;
      if (t == 200) idle_pct = 9;
      if (t == 150) wait_drained();
      issue_random();
    end

    wait_drained();
    // a stray strobe would show up within one full-length computation
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
